// ===== sv/atlb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atlb_pkg: shared types and codes of the associative TLB
// Operation, status and maintenance codes, controller state and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package atlb_pkg;

   localparam int NUM_TABLES = 3;
   localparam int T_UNI      = 0;
   localparam int T_INST     = 1;
   localparam int T_DATA     = 2;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_MAINT  = 2'd2;

   localparam logic [1:0] SEL_UNI  = 2'd0;
   localparam logic [1:0] SEL_INST = 2'd1;
   localparam logic [1:0] SEL_DATA = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_UNKNOWN  = 2'd2;
   localparam logic [1:0] ST_UNSUPP   = 2'd3;

   localparam logic [6:0] FN_FLUSH     = 7'b0000111;
   localparam logic [6:0] FN_INV_UNI   = 7'b0010111;
   localparam logic [6:0] FN_CLR_INST  = 7'b0000101;
   localparam logic [6:0] FN_INV_INST  = 7'b0010101;
   localparam logic [6:0] FN_CLR_DATA  = 7'b0000110;
   localparam logic [6:0] FN_INV_DATA  = 7'b0010110;

   localparam logic [1:0] CSR_MODE    = 2'd0;
   localparam logic [1:0] CSR_UNI_N   = 2'd1;
   localparam logic [1:0] CSR_INST_N  = 2'd2;
   localparam logic [1:0] CSR_DATA_N  = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT,
      S_DELIVER
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } stat_type;

endpackage
`default_nettype wire

// ===== sv/assoc_tlb_random_replace.sv =====
`default_nettype none
// Each transaction scans every pair memory through its single read port, one
// slot a cycle; the next request is accepted only once the block is back in
// its idle state, after the previous response has been loaded.
// A waiting response does not block acceptance of the next request.
// Reset (synchronous, active high) clears all valid bits and the handshake
// state and restores the configuration to unified mode with 64 entries each.
// ----------------------------------------------------------------------------
// assoc_tlb_random_replace: fully associative TLB with random replacement
// A unified table, or separate instruction and data tables, searched by a
// sequential scan; inserts, flushes and invalidates follow the scan.
// ----------------------------------------------------------------------------
module assoc_tlb_random_replace #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [1:0]  csr_index,
   input  wire  [6:0]  csr_wdata,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_operation,
   input  wire  [1:0]  req_table_select,
   input  wire  [31:0] req_virt_addr,
   input  wire  [31:0] req_phys_addr,
   input  wire  [5:0]  req_victim_slot,
   input  wire  [2:0]  req_func_op2,
   input  wire  [3:0]  req_func_crm,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_hit,
   output logic        rsp_hit_inst,
   output logic        rsp_hit_data,
   output logic [31:0] rsp_translated_addr,
   output logic [1:0]  rsp_status
);
   import atlb_pkg::*;

   // The controller sequences each transaction through scan, commit and
   // delivery; the datapath owns every table and the response register.
   cmd_type  cmd;
   stat_type stat;

   atlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Each scan compares one slot of all three tables at once, so a lookup
   // in separate mode sees both sides in the same pass.
   atlb_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_operation       (req_operation),
      .req_table_select    (req_table_select),
      .req_virt_addr       (req_virt_addr),
      .req_phys_addr       (req_phys_addr),
      .req_victim_slot     (req_victim_slot),
      .req_func_op2        (req_func_op2),
      .req_func_crm        (req_func_crm),
      .rsp_hit             (rsp_hit),
      .rsp_hit_inst        (rsp_hit_inst),
      .rsp_hit_data        (rsp_hit_data),
      .rsp_translated_addr (rsp_translated_addr),
      .rsp_status          (rsp_status)
   );

endmodule
`default_nettype wire

// ===== sv/atlb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atlb_ctrl: transaction sequencer of the associative TLB
// Accepts a request, runs the table scan, commits the update and hands the
// response to the output register.
// ----------------------------------------------------------------------------
module atlb_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   input  atlb_pkg::stat_type stat,
   output atlb_pkg::cmd_type  cmd
);
   import atlb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_DELIVER;
         end
         S_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== sv/atlb_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atlb_dpath: tables, scan engine and result register of the associative TLB
// Three pair memories are read one slot a cycle; per table the first match
// and the first free slot in use are collected, then the update is applied.
// ----------------------------------------------------------------------------
module atlb_dpath #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  atlb_pkg::cmd_type  cmd,
   output atlb_pkg::stat_type stat,
   input  wire                csr_wr_en,
   input  wire  [1:0]         csr_index,
   input  wire  [6:0]         csr_wdata,
   input  wire  [1:0]         req_operation,
   input  wire  [1:0]         req_table_select,
   input  wire  [31:0]        req_virt_addr,
   input  wire  [31:0]        req_phys_addr,
   input  wire  [5:0]         req_victim_slot,
   input  wire  [2:0]         req_func_op2,
   input  wire  [3:0]         req_func_crm,
   output logic               rsp_hit,
   output logic               rsp_hit_inst,
   output logic               rsp_hit_data,
   output logic [31:0]        rsp_translated_addr,
   output logic [1:0]         rsp_status
);
   import atlb_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int NW = $clog2(MAX_ENTRIES + 1);

   function automatic logic [NW-1:0] in_use(input logic [6:0] n);
      if (n == 7'd0) begin
         return NW'(1);
      end else if (int'(n) > MAX_ENTRIES) begin
         return NW'(MAX_ENTRIES);
      end else begin
         return NW'(n);
      end
   endfunction

   // Configuration
   logic       mode_ff;
   logic [6:0] ent_ff [NUM_TABLES];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         for (int t = 0; t < NUM_TABLES; t++) begin
            ent_ff[t] <= 7'd64;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:   mode_ff        <= csr_wdata[0];
            CSR_UNI_N:  ent_ff[T_UNI]  <= csr_wdata;
            CSR_INST_N: ent_ff[T_INST] <= csr_wdata;
            CSR_DATA_N: ent_ff[T_DATA] <= csr_wdata;
            default:    mode_ff        <= mode_ff;
         endcase
      end
   end

   // Captured request
   logic [1:0]  op_ff, sel_ff;
   logic [31:0] va_ff, pa_ff;
   logic [5:0]  vic_ff;
   logic [6:0]  code_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= req_operation;
         sel_ff  <= req_table_select;
         va_ff   <= req_virt_addr;
         pa_ff   <= req_phys_addr;
         vic_ff  <= req_victim_slot;
         code_ff <= {req_func_op2, req_func_crm};
      end
   end

   // Scan counters
   logic [IW:0]   rd_idx_ff;
   logic [IW-1:0] cmp_idx_ff;
   logic          cmp_vld_ff;
   logic          ren;

   assign ren = cmd.scan && (int'(rd_idx_ff) < MAX_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= (IW+1)'(MAX_ENTRIES);
         cmp_vld_ff <= 1'b0;
      end else if (cmd.start) begin
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= ren;
         if (ren) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ren) begin
         cmp_idx_ff <= rd_idx_ff[IW-1:0];
      end
   end

   assign stat.scan_done = cmp_vld_ff && (cmp_idx_ff == IW'(MAX_ENTRIES - 1));

   // Commit decode
   logic             we     [NUM_TABLES];
   logic             clr    [NUM_TABLES];
   logic             er     [NUM_TABLES];
   logic [IW-1:0]    wslot  [NUM_TABLES];
   logic             found_ff [NUM_TABLES];
   logic [IW-1:0]    fidx_ff  [NUM_TABLES];
   logic [31:0]      fpa_ff   [NUM_TABLES];
   logic             free_ff  [NUM_TABLES];
   logic [IW-1:0]    freex_ff [NUM_TABLES];
   logic [NW-1:0]    nuse     [NUM_TABLES];
   logic [1:0]       status_calc;
   logic             mismatch;

   always_comb begin
      mismatch    = 1'b0;
      status_calc = ST_OK;
      for (int t = 0; t < NUM_TABLES; t++) begin
         we[t]  = 1'b0;
         clr[t] = 1'b0;
         er[t]  = 1'b0;
      end
      case (op_ff)
         OP_LOOKUP: status_calc = ST_OK;
         OP_INSERT: begin
            case (sel_ff)
               SEL_UNI:  we[T_UNI]  = 1'b1;
               SEL_INST: we[T_INST] = 1'b1;
               SEL_DATA: we[T_DATA] = 1'b1;
               default:  status_calc = ST_UNSUPP;
            endcase
         end
         OP_MAINT: begin
            case (code_ff)
               FN_FLUSH: begin
                  clr[T_UNI]  = !mode_ff;
                  clr[T_INST] = mode_ff;
                  clr[T_DATA] = mode_ff;
               end
               FN_INV_UNI: begin
                  mismatch  = mode_ff;
                  er[T_UNI] = !mode_ff;
               end
               FN_CLR_INST: clr[T_INST] = 1'b1;
               FN_INV_INST: begin
                  mismatch   = !mode_ff;
                  er[T_INST] = mode_ff;
               end
               FN_CLR_DATA: clr[T_DATA] = 1'b1;
               FN_INV_DATA: begin
                  mismatch   = !mode_ff;
                  er[T_DATA] = mode_ff;
               end
               default: status_calc = ST_UNKNOWN;
            endcase
            if (mismatch) begin
               status_calc = ST_MISMATCH;
               for (int t = 0; t < NUM_TABLES; t++) begin
                  er[t] = 1'b1;
               end
            end
         end
         default: status_calc = ST_UNKNOWN;
      endcase
   end

   // One table: pair memory, valid bits and scan accumulators
   for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tab
      logic [63:0]            mem [MAX_ENTRIES];
      logic [63:0]            rdata_ff;
      logic [MAX_ENTRIES-1:0] vld_ff;
      logic                   match;
      logic                   is_free;

      assign nuse[t] = in_use(ent_ff[t]);

      always_comb begin
         if (found_ff[t]) begin
            wslot[t] = fidx_ff[t];
         end else if (free_ff[t]) begin
            wslot[t] = freex_ff[t];
         end else if (int'(vic_ff) >= int'(nuse[t])) begin
            wslot[t] = IW'(nuse[t] - NW'(1));
         end else begin
            wslot[t] = IW'(vic_ff);
         end
      end

      always_ff @(posedge clock) begin
         if (ren) begin
            rdata_ff <= mem[rd_idx_ff[IW-1:0]];
         end
         if (cmd.commit && we[t]) begin
            mem[wslot[t]] <= {va_ff, pa_ff};
         end
      end

      assign match   = vld_ff[cmp_idx_ff] && (rdata_ff[63:32] == va_ff);
      assign is_free = !vld_ff[cmp_idx_ff] && (int'(cmp_idx_ff) < int'(nuse[t]));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= '0;
         end else if (cmd.commit) begin
            if (clr[t]) begin
               vld_ff <= '0;
            end else if (er[t] && found_ff[t]) begin
               vld_ff[fidx_ff[t]] <= 1'b0;
            end else if (we[t]) begin
               vld_ff[wslot[t]] <= 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.start) begin
            found_ff[t] <= 1'b0;
            free_ff[t]  <= 1'b0;
         end else if (cmp_vld_ff) begin
            if (match && !found_ff[t]) begin
               found_ff[t] <= 1'b1;
               fidx_ff[t]  <= cmp_idx_ff;
               fpa_ff[t]   <= rdata_ff[31:0];
            end
            if (is_free && !free_ff[t]) begin
               free_ff[t]  <= 1'b1;
               freex_ff[t] <= cmp_idx_ff;
            end
         end
      end
   end

   // Response register
   logic        hit_calc, hi_calc, hd_calc;
   logic [31:0] addr_calc;
   logic        hit_ff, hit_inst_ff, hit_data_ff;
   logic [31:0] addr_ff;
   logic [1:0]  status_ff;

   always_comb begin
      hit_calc  = 1'b0;
      hi_calc   = 1'b0;
      hd_calc   = 1'b0;
      addr_calc = '0;
      if (op_ff == OP_LOOKUP) begin
         if (!mode_ff) begin
            if (found_ff[T_UNI]) begin
               hit_calc  = 1'b1;
               addr_calc = fpa_ff[T_UNI];
            end
         end else if (found_ff[T_INST]) begin
            hit_calc  = 1'b1;
            hi_calc   = 1'b1;
            addr_calc = fpa_ff[T_INST];
         end else if (found_ff[T_DATA]) begin
            hit_calc  = 1'b1;
            hd_calc   = 1'b1;
            addr_calc = fpa_ff[T_DATA];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff      <= hit_calc;
         hit_inst_ff <= hi_calc;
         hit_data_ff <= hd_calc;
         addr_ff     <= addr_calc;
         status_ff   <= status_calc;
      end
   end

   assign rsp_hit             = hit_ff;
   assign rsp_hit_inst        = hit_inst_ff;
   assign rsp_hit_data        = hit_data_ff;
   assign rsp_translated_addr = addr_ff;
   assign rsp_status          = status_ff;

endmodule
`default_nettype wire

// ===== sv/atlb_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atlb_checker: port-level checks of the associative TLB
// Response consistency and the output handshake, bound to the top level.
// ----------------------------------------------------------------------------
module atlb_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_hit,
   input wire        rsp_hit_inst,
   input wire        rsp_hit_data,
   input wire [31:0] rsp_translated_addr,
   input wire [1:0]  rsp_status
);

   // A stalled response stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A miss or a non-lookup transaction returns a zero address.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_translated_addr == 32'd0)
      else $error("address returned without a hit");

   // A side flag only comes with a hit, and never both sides.
   a_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hit_inst || rsp_hit_data) |-> rsp_hit && !(rsp_hit_inst && rsp_hit_data))
      else $error("inconsistent hit side");

   // Only a lookup can hit, and a lookup always completes cleanly.
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_status == 2'd0)
      else $error("hit reported with an error status");

endmodule

bind assoc_tlb_random_replace atlb_checker u_atlb_checker (.*);
`default_nettype wire

// ===== tb/assoc_tlb_random_replace_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_tlb_random_replace_test: self-checking bench for the associative TLB
// Drives lookups, inserts and maintenance functions in both table modes and at
// several table sizes, predicts every response from a behavioural copy of the
// three tables and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module assoc_tlb_random_replace_test;
   import atlb_pkg::*;

   localparam int N = 64;
   localparam int LATENCY = N + 3;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic        hit;
      logic        hit_inst;
      logic        hit_data;
      logic [31:0] addr;
      logic [1:0]  status;
   } tlb_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [1:0]  req_table_select = '0;
   logic [31:0] req_virt_addr = '0;
   logic [31:0] req_phys_addr = '0;
   logic [5:0]  req_victim_slot = '0;
   logic [2:0]  req_func_op2 = '0;
   logic [3:0]  req_func_crm = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit, rsp_hit_inst, rsp_hit_data;
   logic [31:0] rsp_translated_addr;
   logic [1:0]  rsp_status;

   assoc_tlb_random_replace #(.MAX_ENTRIES(N)) i_dut (.*);

   always #5 clock = ~clock;

   // Model of the three tables: index T_UNI, T_INST or T_DATA.
   logic        tab_valid [NUM_TABLES][N];
   logic [31:0] tab_va    [NUM_TABLES][N];
   logic [31:0] tab_pa    [NUM_TABLES][N];
   logic        mode_sep;
   logic [6:0]  tab_size  [NUM_TABLES];

   tlb_rsp_type expected_rsps[$];
   int       mismatches = 0;
   longint   cycles = 0;
   bit       hold_off = 0;    // set by the back-pressure test
   bit       bursty = 1;      // random response stalls enabled

   // A small pool of addresses keeps hits, duplicates and invalidates common.
   logic [31:0] va_pool[16];

   function automatic int find_entry(int t, logic [31:0] va);
      for (int i = 0; i < N; i++)
         if (tab_valid[t][i] && tab_va[t][i] == va) return i;
      return -1;
   endfunction

   function automatic void erase_entry(int t, logic [31:0] va);
      int i;
      i = find_entry(t, va);
      if (i >= 0) tab_valid[t][i] = 1'b0;
   endfunction

   function automatic void clear_table(int t);
      for (int i = 0; i < N; i++) tab_valid[t][i] = 1'b0;
   endfunction

   function automatic void insert_entry(int t, logic [31:0] va, logic [31:0] pa,
                                        logic [5:0] victim);
      int n, slot;
      n = (tab_size[t] == 0) ? 1 : (tab_size[t] > N) ? N : tab_size[t];
      slot = find_entry(t, va);
      if (slot < 0)
         for (int i = 0; i < n; i++)
            if (!tab_valid[t][i]) begin
               slot = i;
               break;
            end
      if (slot < 0) slot = (victim >= n) ? n - 1 : victim;
      tab_valid[t][slot] = 1'b1;
      tab_va[t][slot]    = va;
      tab_pa[t][slot]    = pa;
   endfunction

   // Applies one request to the tables and returns the response it causes.
   function automatic tlb_rsp_type translate(logic [1:0] op, logic [1:0] sel,
         logic [31:0] va, logic [31:0] pa, logic [5:0] victim, logic [6:0] code);
      tlb_rsp_type r;
      int i;
      bit mismatch;
      r = '0;
      mismatch = 0;
      case (op)
         OP_LOOKUP: begin
            if (!mode_sep) begin
               i = find_entry(T_UNI, va);
               if (i >= 0) begin
                  r.hit = 1; r.addr = tab_pa[T_UNI][i];
               end
            end else begin
               i = find_entry(T_INST, va);
               if (i >= 0) begin
                  r.hit = 1; r.hit_inst = 1; r.addr = tab_pa[T_INST][i];
               end else begin
                  i = find_entry(T_DATA, va);
                  if (i >= 0) begin
                     r.hit = 1; r.hit_data = 1; r.addr = tab_pa[T_DATA][i];
                  end
               end
            end
         end
         OP_INSERT: begin
            case (sel)
               SEL_UNI:  insert_entry(T_UNI, va, pa, victim);
               SEL_INST: insert_entry(T_INST, va, pa, victim);
               SEL_DATA: insert_entry(T_DATA, va, pa, victim);
               default:  r.status = ST_UNSUPP;
            endcase
         end
         OP_MAINT: begin
            case (code)
               FN_FLUSH:
                  if (!mode_sep) clear_table(T_UNI);
                  else begin
                     clear_table(T_INST); clear_table(T_DATA);
                  end
               FN_INV_UNI:  if (mode_sep) mismatch = 1; else erase_entry(T_UNI, va);
               FN_CLR_INST: clear_table(T_INST);
               FN_INV_INST: if (!mode_sep) mismatch = 1; else erase_entry(T_INST, va);
               FN_CLR_DATA: clear_table(T_DATA);
               FN_INV_DATA: if (!mode_sep) mismatch = 1; else erase_entry(T_DATA, va);
               default:     r.status = ST_UNKNOWN;
            endcase
            if (mismatch) begin
               for (int t = 0; t < NUM_TABLES; t++) erase_entry(t, va);
               r.status = ST_MISMATCH;
            end
         end
         default: r.status = ST_UNKNOWN;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Response checker, with random stalls and the long hold-off on request.
   always @(posedge clock) begin
      tlb_rsp_type exp_r;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response, addr", rsp_translated_addr, 0);
         end else begin
            exp_r = expected_rsps.pop_front();
            if (rsp_hit !== exp_r.hit)
               report_mismatch("hit", 32'(rsp_hit), 32'(exp_r.hit));
            if (rsp_hit_inst !== exp_r.hit_inst)
               report_mismatch("hit_inst", 32'(rsp_hit_inst), 32'(exp_r.hit_inst));
            if (rsp_hit_data !== exp_r.hit_data)
               report_mismatch("hit_data", 32'(rsp_hit_data), 32'(exp_r.hit_data));
            if (rsp_translated_addr !== exp_r.addr)
               report_mismatch("translated_addr", rsp_translated_addr, exp_r.addr);
            if (rsp_status !== exp_r.status)
               report_mismatch("status", 32'(rsp_status), 32'(exp_r.status));
         end
      end
      if (hold_off) rsp_stall <= 1'b1;
      else if (bursty) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= 1'b0;
   end

   always @(posedge clock)
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end

   // Sends one transaction; the prediction is made when the block accepts it.
   // Valid stays high after acceptance unless a gap follows, so that a
   // transaction sent straight after another keeps valid asserted.
   task automatic send_request(logic [1:0] op, logic [1:0] sel, logic [31:0] va,
         logic [31:0] pa, logic [5:0] victim, logic [2:0] op2, logic [3:0] crm);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_table_select <= sel;
      req_virt_addr    <= va;
      req_phys_addr    <= pa;
      req_victim_slot  <= victim;
      req_func_op2     <= op2;
      req_func_crm     <= crm;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(translate(op, sel, va, pa, victim, {op2, crm}));
   endtask

   // Waits for every response, then lets the block settle before a write.
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [6:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MODE:   mode_sep = value[0];
         CSR_UNI_N:  tab_size[T_UNI] = value;
         CSR_INST_N: tab_size[T_INST] = value;
         default:    tab_size[T_DATA] = value;
      endcase
   endtask

   task automatic configure(logic sep, logic [6:0] nu, logic [6:0] ni, logic [6:0] nd);
      drain();
      write_csr(CSR_MODE, {6'd0, sep});
      write_csr(CSR_UNI_N, nu);
      write_csr(CSR_INST_N, ni);
      write_csr(CSR_DATA_N, nd);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_va();
      return ($urandom_range(0, 7) == 0) ? $urandom : va_pool[$urandom_range(0, 15)];
   endfunction

   // Mostly well-formed traffic: inserts into the tables the mode uses,
   // lookups of known addresses, and the occasional maintenance function.
   task automatic random_request;
      logic [1:0] op, sel;
      logic [6:0] code;
      int r;
      r = $urandom_range(0, 99);
      sel = mode_sep ? 2'($urandom_range(1, 2)) : SEL_UNI;
      if ($urandom_range(0, 19) == 0) sel = 2'($urandom_range(0, 3));
      code = FN_FLUSH;
      if (r < 40) op = OP_LOOKUP;
      else if (r < 85) op = OP_INSERT;
      else if (r < 98) begin
         op = OP_MAINT;
         case ($urandom_range(0, 9))
            0:       code = FN_FLUSH;
            1:       code = FN_CLR_INST;
            2:       code = FN_CLR_DATA;
            3, 4:    code = FN_INV_UNI;
            5, 6:    code = FN_INV_INST;
            7, 8:    code = FN_INV_DATA;
            default: code = 7'($urandom_range(0, 127));
         endcase
      end else op = 2'd3;
      send_request(op, sel, pick_va(), $urandom, 6'($urandom_range(0, 63)),
                   code[6:4], code[3:0]);
   endtask

   task automatic test_directed;
      send_request(OP_LOOKUP, SEL_UNI, 32'h0, 0, 0, 0, 0);
      send_request(OP_INSERT, SEL_UNI, 32'h0, 32'hFFFF_FFFF, 0, 0, 0);
      send_request(OP_INSERT, SEL_UNI, 32'hFFFF_FFFF, 32'h0, 63, 0, 0);
      send_request(OP_LOOKUP, SEL_UNI, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send_request(OP_LOOKUP, SEL_UNI, 32'h0, 0, 0, 0, 0);
      // A duplicate insert updates the existing entry in place.
      send_request(OP_INSERT, SEL_UNI, 32'h0, 32'h1234_5678, 0, 0, 0);
      send_request(OP_LOOKUP, SEL_UNI, 32'h0, 0, 0, 0, 0);
      // Unsupported selection, operation three and an unknown function.
      send_request(OP_INSERT, 2'd3, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 7, 15);
      send_request(2'd3, SEL_UNI, 32'h0, 0, 0, 0, 0);
      send_request(OP_MAINT, SEL_UNI, 0, 0, 0, 3'd7, 4'd15);
      // Inserts into tables that unified mode does not search.
      send_request(OP_INSERT, SEL_INST, 32'h0, 32'h1111_1111, 5, 0, 0);
      send_request(OP_INSERT, SEL_DATA, 32'h0, 32'h2222_2222, 5, 0, 0);
      // Mismatched invalidate removes the address from all three tables.
      send_request(OP_MAINT, SEL_UNI, 32'h0, 0, 0, FN_INV_INST[6:4], FN_INV_INST[3:0]);
      send_request(OP_LOOKUP, SEL_UNI, 32'h0, 0, 0, 0, 0);
      send_request(OP_MAINT, SEL_UNI, 32'hFFFF_FFFF, 0, 0,
                   FN_INV_UNI[6:4], FN_INV_UNI[3:0]);
      send_request(OP_MAINT, SEL_UNI, 0, 0, 0, FN_FLUSH[6:4], FN_FLUSH[3:0]);
      send_request(OP_MAINT, SEL_UNI, 0, 0, 0, FN_CLR_INST[6:4], FN_CLR_INST[3:0]);
      send_request(OP_MAINT, SEL_UNI, 0, 0, 0, FN_CLR_DATA[6:4], FN_CLR_DATA[3:0]);
      send_request(OP_MAINT, SEL_UNI, 0, 0, 0, FN_INV_DATA[6:4], FN_INV_DATA[3:0]);
   endtask

   // Separate mode with tiny tables: fills, victim clamping and side flags.
   task automatic test_separate_small;
      configure(1'b1, 7'd0, 7'd1, 7'd2);
      send_request(OP_INSERT, SEL_INST, 32'h10, 32'hA0, 63, 0, 0);
      send_request(OP_INSERT, SEL_INST, 32'h11, 32'hA1, 63, 0, 0);
      send_request(OP_INSERT, SEL_DATA, 32'h10, 32'hB0, 0, 0, 0);
      send_request(OP_INSERT, SEL_DATA, 32'h20, 32'hB1, 0, 0, 0);
      send_request(OP_INSERT, SEL_DATA, 32'h21, 32'hB2, 63, 0, 0);
      send_request(OP_LOOKUP, SEL_UNI, 32'h11, 0, 0, 0, 0);
      send_request(OP_LOOKUP, SEL_UNI, 32'h10, 0, 0, 0, 0);
      send_request(OP_LOOKUP, SEL_UNI, 32'h21, 0, 0, 0, 0);
      send_request(OP_MAINT, SEL_UNI, 32'h11, 0, 0, FN_INV_UNI[6:4], FN_INV_UNI[3:0]);
      send_request(OP_LOOKUP, SEL_UNI, 32'h11, 0, 0, 0, 0);
      for (int i = 0; i < 150; i++) random_request();
   endtask

   // Shrinking a full table leaves the upper entries searchable.
   task automatic test_shrink;
      configure(1'b0, 7'd127, 7'd64, 7'd64);
      for (int i = 0; i < 70; i++)
         send_request(OP_INSERT, SEL_UNI, 32'h100 + i, $urandom,
                      6'($urandom_range(0, 63)), 0, 0);
      configure(1'b0, 7'd3, 7'd64, 7'd64);
      for (int i = 0; i < 70; i++) begin
         if (i % 2)
            send_request(OP_LOOKUP, SEL_UNI, 32'h100 + $urandom_range(0, 69),
                         0, 0, 0, 0);
         else random_request();
      end
   endtask

   // The receiver holds off so that the block fills up and stalls requests.
   task automatic test_backpressure;
      fork
         begin
            hold_off = 1;
            repeat (2000) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 12; i++) random_request();
      join
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) bursty = ~bursty;
         random_request();
      end
   endtask

   initial begin
      for (int i = 0; i < 16; i++) va_pool[i] = $urandom;
      va_pool[0] = 32'h0;
      va_pool[1] = 32'hFFFF_FFFF;
      for (int t = 0; t < NUM_TABLES; t++) begin
         clear_table(t);
         tab_size[t] = 7'd64;
      end
      mode_sep = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_separate_small();
      test_shrink();
      test_backpressure();
      configure(1'b0, 7'd8, 7'd64, 7'd64);
      test_random(350);
      configure(1'b1, 7'd64, 7'd5, 7'd64);
      test_random(350);
      configure(1'b1, 7'd64, 7'd64, 7'd3);
      test_random(250);
      configure(1'b0, 7'd2, 7'd1, 7'd1);
      test_random(250);

      drain();
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

// ===== assoc_tlb_random_replace.f =====
sv/atlb_pkg.sv
sv/atlb_ctrl.sv
sv/atlb_dpath.sv
sv/assoc_tlb_random_replace.sv
sv/atlb_checker.sv
tb/assoc_tlb_random_replace_test.sv
